// ===== hdl/afb_pkg.sv =====
package afb_pkg;

  // Queue sizing
  localparam int QUEUE_DEPTH = 256;
  localparam int MAX_BATCH   = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int BATCH_W     = $clog2(MAX_BATCH + 1);

  // Field widths
  localparam int SEQ_W  = 32;
  localparam int TIME_W = 48;
  localparam int REV_W  = 32;
  localparam int ID_W   = 32;
  localparam int IV_W   = 24;
  localparam int TRIG_W = 9;
  localparam int LIM_W  = 7;
  localparam int PEND_W = 9;
  localparam int CFG_W  = 24;
  localparam int CMP_W  = (CNT_W > TRIG_W) ? CNT_W : TRIG_W;

  // Register reset values
  localparam logic [IV_W-1:0]   INTERVAL_RST = 24'd100000;
  localparam logic [TRIG_W-1:0] TRIGGER_RST  = 9'd32;
  localparam logic [LIM_W-1:0]  LIMIT_RST    = 7'd64;
  localparam logic [ID_W-1:0]   BATCH_ID_RST = 32'd1;

  typedef enum logic [1:0] {
    ACT_RECORD = 2'd0,
    ACT_TAKE   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_TRIGGER  = 2'd1,
    CFG_LIMIT    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_GAP
  } state_e;

  // Classified request handed from front to back
  typedef struct packed {
    action_e            act;
    logic               fields_ok;
    logic [SEQ_W-1:0]   seq;
    logic [TIME_W-1:0]  now;
    logic [REV_W-1:0]   rev;
  } cmd_t;

  typedef struct packed {
    logic [IV_W-1:0]   interval;
    logic [TRIG_W-1:0] trigger;
    logic [LIM_W-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic              accepted;
    logic              batch_valid;
    logic [ID_W-1:0]   batch_id;
    logic [REV_W-1:0]  batch_revision;
    logic [SEQ_W-1:0]  arrival_sequence;
    logic [TIME_W-1:0] arrival_time;
    logic              last;
    logic [PEND_W-1:0] pending;
    logic              due;
  } res_t;

  // now + interval, saturating at the top of the time range
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] now,
                                                input logic [IV_W-1:0] iv);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + (TIME_W + 1)'(iv);
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

  // Feedback due: something pending and either count trigger or due time hit
  function automatic logic is_due(input logic [CNT_W-1:0] count,
                                  input logic [TRIG_W-1:0] trig,
                                  input logic [TIME_W-1:0] due_t,
                                  input logic [TIME_W-1:0] now);
    logic by_count;
    logic by_time;
    by_count = CMP_W'(count) >= CMP_W'(trig);
    by_time  = (due_t != '0) && (now >= due_t);
    return (count != '0) && (by_count || by_time);
  endfunction

endpackage

// ===== hdl/afb_front.sv =====
module afb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [afb_pkg::SEQ_W-1:0]   sequence_req_i,
  input  logic [afb_pkg::TIME_W-1:0]  now_us_i,
  input  logic [afb_pkg::REV_W-1:0]   revision_i,
  output logic                        cmd_valid_o,
  output afb_pkg::cmd_t               cmd_o,
  input  logic                        cmd_pop_i
);

  afb_pkg::cmd_t ent_q [2];
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;
  afb_pkg::cmd_t cls;

  // Classify the incoming request
  always_comb begin
    cls.act       = afb_pkg::action_e'(action_i);
    cls.fields_ok = (sequence_req_i != '0) && (now_us_i != '0) && (revision_i != '0);
    cls.seq       = sequence_req_i;
    cls.now       = now_us_i;
    cls.rev       = revision_i;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rd_q];

  // Two-entry queue pointers
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = cmd_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= cls;
    end
  end

endmodule

// ===== hdl/afb_back.sv =====
module afb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  afb_pkg::cfg_t  cfg_i,
  input  logic           cmd_valid_i,
  input  afb_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output afb_pkg::res_t  res_o
);

  localparam int ENT_W = afb_pkg::SEQ_W + afb_pkg::TIME_W;

  // Arrival store, one write and one registered read port
  logic [ENT_W-1:0] mem [afb_pkg::QUEUE_DEPTH];
  logic [ENT_W-1:0] rd_data_q;
  logic             mem_we;
  logic [afb_pkg::PTR_W-1:0] tail;

  afb_pkg::state_e state_q, state_d;
  logic [afb_pkg::PTR_W-1:0]   head_q, head_d;
  logic [afb_pkg::CNT_W-1:0]   count_q, count_d;
  logic [afb_pkg::SEQ_W-1:0]   last_seq_q, last_seq_d;
  logic [afb_pkg::REV_W-1:0]   held_rev_q, held_rev_d;
  logic [afb_pkg::TIME_W-1:0]  due_time_q, due_time_d;
  logic [afb_pkg::ID_W-1:0]    next_id_q, next_id_d;
  logic [afb_pkg::ID_W-1:0]    batch_id_q, batch_id_d;
  logic [afb_pkg::BATCH_W-1:0] remain_q, remain_d;
  logic                        due_after_q, due_after_d;
  logic                        out_valid_q, out_valid_d;
  afb_pkg::res_t               out_q, out_d;
  logic                        out_load;

  logic                        slot_free;
  logic [afb_pkg::CNT_W:0]     tail_sum;
  logic [afb_pkg::PTR_W-1:0]   head_inc;
  logic [afb_pkg::TIME_W-1:0]  armed_time;
  logic                        rec_ok, rev_change, fifo_full, rec_push;
  logic [afb_pkg::CNT_W-1:0]   rec_count;
  logic [afb_pkg::TIME_W-1:0]  rec_due_t;
  logic                        rec_due;
  logic                        take_due;
  logic [afb_pkg::LIM_W-1:0]   lim7;
  logic [afb_pkg::BATCH_W-1:0] lim, n;
  logic [afb_pkg::CNT_W-1:0]   rem;
  logic [afb_pkg::TIME_W-1:0]  take_due_t;
  logic                        take_due_after;
  logic                        start_take;

  assign slot_free = !out_valid_q || !out_stall_i;

  // Queue pointer arithmetic
  always_comb begin
    tail_sum = (afb_pkg::CNT_W + 1)'(head_q) + (afb_pkg::CNT_W + 1)'(count_q);
    if (tail_sum >= (afb_pkg::CNT_W + 1)'(afb_pkg::QUEUE_DEPTH)) begin
      tail = afb_pkg::PTR_W'(tail_sum - (afb_pkg::CNT_W + 1)'(afb_pkg::QUEUE_DEPTH));
    end else begin
      tail = afb_pkg::PTR_W'(tail_sum);
    end
    if (head_q == afb_pkg::PTR_W'(afb_pkg::QUEUE_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_q + 1'b1;
    end
  end

  // Record evaluation
  always_comb begin
    armed_time = afb_pkg::sat_add(cmd_i.now, cfg_i.interval);
    rec_ok     = cmd_i.fields_ok && (cmd_i.seq > last_seq_q);
    rev_change = (count_q != '0) && (held_rev_q != cmd_i.rev);
    fifo_full  = (count_q == afb_pkg::CNT_W'(afb_pkg::QUEUE_DEPTH));
    rec_push   = rec_ok && !rev_change && !fifo_full;
    rec_count  = count_q + afb_pkg::CNT_W'(rec_push);
    if (rec_ok && rev_change) begin
      rec_due_t = cmd_i.now;
    end else if (rec_push && (due_time_q == '0)) begin
      rec_due_t = armed_time;
    end else begin
      rec_due_t = due_time_q;
    end
    rec_due = afb_pkg::is_due(rec_count, cfg_i.trigger, rec_due_t, cmd_i.now);
  end

  // Take evaluation: batch size and state after the batch
  always_comb begin
    take_due = afb_pkg::is_due(count_q, cfg_i.trigger, due_time_q, cmd_i.now);
    if (cfg_i.limit == '0) begin
      lim7 = afb_pkg::LIM_W'(1);
    end else if (cfg_i.limit > afb_pkg::LIM_W'(afb_pkg::MAX_BATCH)) begin
      lim7 = afb_pkg::LIM_W'(afb_pkg::MAX_BATCH);
    end else begin
      lim7 = cfg_i.limit;
    end
    lim = afb_pkg::BATCH_W'(lim7);
    if (afb_pkg::CNT_W'(lim) > count_q) begin
      n = afb_pkg::BATCH_W'(count_q);
    end else begin
      n = lim;
    end
    rem            = count_q - afb_pkg::CNT_W'(n);
    take_due_t     = (rem == '0) ? '0 : armed_time;
    take_due_after = afb_pkg::is_due(rem, cfg_i.trigger, take_due_t, cmd_i.now);
  end

  assign start_take = cmd_valid_i && slot_free && (cmd_i.act == afb_pkg::ACT_TAKE) && take_due;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      afb_pkg::ST_IDLE: begin
        if (start_take) begin
          state_d = afb_pkg::ST_EMIT;
        end
      end
      afb_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_d = (remain_q == afb_pkg::BATCH_W'(1)) ? afb_pkg::ST_IDLE : afb_pkg::ST_GAP;
        end
      end
      afb_pkg::ST_GAP: begin
        state_d = afb_pkg::ST_EMIT;
      end
      default: state_d = afb_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    last_seq_d  = last_seq_q;
    held_rev_d  = held_rev_q;
    due_time_d  = due_time_q;
    next_id_d   = next_id_q;
    batch_id_d  = batch_id_q;
    remain_d    = remain_q;
    due_after_d = due_after_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = '0;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    cmd_pop_o   = 1'b0;
    out_d.last  = 1'b1;

    unique case (state_q)
      afb_pkg::ST_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.act)
            afb_pkg::ACT_RECORD: begin
              out_load       = 1'b1;
              out_d.accepted = rec_push;
              out_d.pending  = afb_pkg::PEND_W'(rec_count);
              out_d.due      = rec_due;
              due_time_d     = rec_due_t;
              if (rec_push) begin
                mem_we     = 1'b1;
                count_d    = rec_count;
                last_seq_d = cmd_i.seq;
                held_rev_d = cmd_i.rev;
              end
            end
            afb_pkg::ACT_TAKE: begin
              if (take_due) begin
                batch_id_d  = next_id_q;
                next_id_d   = next_id_q + 1'b1;
                due_time_d  = take_due_t;
                due_after_d = take_due_after;
                remain_d    = n;
              end else begin
                out_load      = 1'b1;
                out_d.pending = afb_pkg::PEND_W'(count_q);
              end
            end
            afb_pkg::ACT_CLEAR: begin
              out_load   = 1'b1;
              head_d     = '0;
              count_d    = '0;
              last_seq_d = '0;
              held_rev_d = '0;
              due_time_d = '0;
              next_id_d  = afb_pkg::BATCH_ID_RST;
            end
            default: begin
              out_load      = 1'b1;
              out_d.pending = afb_pkg::PEND_W'(count_q);
              out_d.due     = take_due;
            end
          endcase
        end
      end
      afb_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_load               = 1'b1;
          out_d.accepted         = 1'b1;
          out_d.batch_valid      = 1'b1;
          out_d.batch_id         = batch_id_q;
          out_d.batch_revision   = held_rev_q;
          out_d.arrival_sequence = rd_data_q[ENT_W-1:afb_pkg::TIME_W];
          out_d.arrival_time     = rd_data_q[afb_pkg::TIME_W-1:0];
          out_d.last             = (remain_q == afb_pkg::BATCH_W'(1));
          out_d.pending          = afb_pkg::PEND_W'(count_q - afb_pkg::CNT_W'(1));
          out_d.due              = due_after_q;
          head_d                 = head_inc;
          count_d                = count_q - afb_pkg::CNT_W'(1);
          remain_d               = remain_q - afb_pkg::BATCH_W'(1);
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afb_pkg::ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      last_seq_q  <= '0;
      held_rev_q  <= '0;
      due_time_q  <= '0;
      next_id_q   <= afb_pkg::BATCH_ID_RST;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      last_seq_q  <= last_seq_d;
      held_rev_q  <= held_rev_d;
      due_time_q  <= due_time_d;
      next_id_q   <= next_id_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    batch_id_q  <= batch_id_d;
    due_after_q <= due_after_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Arrival store: write at the tail, read at the head every cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail] <= {cmd_i.seq, cmd_i.now};
    end
    rd_data_q <= mem[head_q];
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ===== hdl/arrival_feedback_batcher_top.sv =====
// Arrival feedback batcher.
// Input channel (in_valid_i / in_stall_o) carries one request: record an
// arrival, take a feedback batch, or clear. Output channel (out_valid_o /
// out_stall_i) carries results; last_o marks the final result of a request.
// A request is taken into a two-entry front queue, then executed by the back
// end. A record, clear, unused or not-due take request has its result
// registered from the front queue entry when the back end executes it; a due
// take first decides its batch, then registers its first result.
// Record, clear and unused requests give one result each. A take that is due
// decides, then emits one arrival per result with a gap state between arrivals
// (registered read of the head entry after each head advance), up to the batch
// limit, and the back end takes no new request until its last arrival is out;
// a take that is not due gives one result.
// While the receiver stalls, the result register holds, the back end waits,
// and the front queue fills; in_stall_o rises once both entries are taken.
// Reset empties the queue, clears sequence, revision and due time, sets the
// next batch id to one and loads the register defaults. The arrival store
// holds no reset; only entries written since the last clear are read.
// Configuration writes (cfg_we_i) take effect at once and belong to idle time.
module arrival_feedback_batcher_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [afb_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [afb_pkg::SEQ_W-1:0]    sequence_req_i,
  input  logic [afb_pkg::TIME_W-1:0]   now_us_i,
  input  logic [afb_pkg::REV_W-1:0]    revision_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         accepted_o,
  output logic                         batch_valid_o,
  output logic [afb_pkg::ID_W-1:0]     batch_id_o,
  output logic [afb_pkg::REV_W-1:0]    batch_revision_o,
  output logic [afb_pkg::SEQ_W-1:0]    arrival_sequence_o,
  output logic [afb_pkg::TIME_W-1:0]   arrival_time_us_o,
  output logic                         last_o,
  output logic [afb_pkg::PEND_W-1:0]   pending_count_o,
  output logic                         due_o
);

  afb_pkg::cfg_t cfg_q;
  afb_pkg::cmd_t cmd;
  afb_pkg::res_t res;
  logic          cmd_valid;
  logic          cmd_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval <= afb_pkg::INTERVAL_RST;
      cfg_q.trigger  <= afb_pkg::TRIGGER_RST;
      cfg_q.limit    <= afb_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        afb_pkg::CFG_INTERVAL: cfg_q.interval <= cfg_wdata_i[afb_pkg::IV_W-1:0];
        afb_pkg::CFG_TRIGGER:  cfg_q.trigger  <= cfg_wdata_i[afb_pkg::TRIG_W-1:0];
        afb_pkg::CFG_LIMIT:    cfg_q.limit    <= cfg_wdata_i[afb_pkg::LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  afb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .sequence_req_i (sequence_req_i),
    .now_us_i       (now_us_i),
    .revision_i     (revision_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  afb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign accepted_o         = res.accepted;
  assign batch_valid_o      = res.batch_valid;
  assign batch_id_o         = res.batch_id;
  assign batch_revision_o   = res.batch_revision;
  assign arrival_sequence_o = res.arrival_sequence;
  assign arrival_time_us_o  = res.arrival_time;
  assign last_o             = res.last;
  assign pending_count_o    = res.pending;
  assign due_o              = res.due;

`ifndef SYNTHESIS
  // A batch result is always an accepted take
  a_batch_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && batch_valid_o |-> accepted_o)
    else $error("batch result without accepted");

  // Only batches produce multi-result runs
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !batch_valid_o |-> last_o)
    else $error("non-batch result not marked last");

  // A batch run that continues must leave arrivals behind
  a_run_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && batch_valid_o && !last_o |-> pending_count_o != '0)
    else $error("batch continues with nothing pending");

  // Nothing pending can never be due
  a_due_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && due_o |-> pending_count_o != '0)
    else $error("due flagged with empty queue");
`endif

endmodule

// ===== tb/arrival_feedback_batcher_top_tb.sv =====
module arrival_feedback_batcher_top_tb;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 8;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 16;
  localparam int PHASES           = 8;
  localparam int RANDOM_PER_PHASE = 15;
  localparam int MAX_GAP          = 40;
  localparam logic [afb_pkg::TIME_W-1:0] TIME_MAX = {afb_pkg::TIME_W{1'b1}};

  typedef struct packed {
    logic [afb_pkg::SEQ_W-1:0]  seq;
    logic [afb_pkg::TIME_W-1:0] at;
  } arrival_t;

  // Mirror of the batcher: arrival queue, sequence/revision tracking, due time
  class feedback_tracker;
    logic [afb_pkg::IV_W-1:0]   interval;
    logic [afb_pkg::TRIG_W-1:0] trigger;
    logic [afb_pkg::LIM_W-1:0]  limit;
    arrival_t                   queued[$];
    logic [afb_pkg::SEQ_W-1:0]  last_seq;
    logic [afb_pkg::REV_W-1:0]  held_rev;
    logic [afb_pkg::TIME_W-1:0] due_at;
    logic [afb_pkg::ID_W-1:0]   next_id;
    afb_pkg::res_t              awaited[$];
    int                         requests;
    int                         results;
    int                         batches;
    int                         errors;

    function new();
      interval = afb_pkg::INTERVAL_RST;
      trigger  = afb_pkg::TRIGGER_RST;
      limit    = afb_pkg::LIMIT_RST;
      requests = 0;
      results  = 0;
      batches  = 0;
      errors   = 0;
      awaited.delete();
      clear_state();
    endfunction

    // clear keeps the registers
    function void clear_state();
      queued.delete();
      last_seq = '0;
      held_rev = '0;
      due_at   = '0;
      next_id  = afb_pkg::BATCH_ID_RST;
    endfunction

    function void set_register(afb_pkg::cfg_idx_e idx, logic [afb_pkg::CFG_W-1:0] val);
      case (idx)
        afb_pkg::CFG_INTERVAL: interval = val[afb_pkg::IV_W-1:0];
        afb_pkg::CFG_TRIGGER:  trigger  = val[afb_pkg::TRIG_W-1:0];
        afb_pkg::CFG_LIMIT:    limit    = val[afb_pkg::LIM_W-1:0];
        default: ;
      endcase
    endfunction

    // now + interval, pinned at the top of the time range
    function logic [afb_pkg::TIME_W-1:0] rearm(logic [afb_pkg::TIME_W-1:0] now);
      logic [afb_pkg::TIME_W:0] sum;
      sum = {1'b0, now} + (afb_pkg::TIME_W + 1)'(interval);
      return sum[afb_pkg::TIME_W] ? TIME_MAX : sum[afb_pkg::TIME_W-1:0];
    endfunction

    function bit due_now(logic [afb_pkg::TIME_W-1:0] now);
      if (queued.size() == 0) return 1'b0;
      if (queued.size() >= int'(trigger)) return 1'b1;
      return (due_at != '0) && (now >= due_at);
    endfunction

    function void push_result(bit acc, bit bv, logic [afb_pkg::ID_W-1:0] id,
                              logic [afb_pkg::REV_W-1:0] rev, arrival_t a, bit last,
                              int pend, bit due);
      afb_pkg::res_t r;
      r.accepted         = acc;
      r.batch_valid      = bv;
      r.batch_id         = id;
      r.batch_revision   = rev;
      r.arrival_sequence = a.seq;
      r.arrival_time     = a.at;
      r.last             = last;
      r.pending          = afb_pkg::PEND_W'(pend);
      r.due              = due;
      awaited.insert(awaited.size(), r);
    endfunction

    // Work out the results of one accepted request
    function void note_request(afb_pkg::action_e act, logic [afb_pkg::SEQ_W-1:0] seq,
                               logic [afb_pkg::TIME_W-1:0] now,
                               logic [afb_pkg::REV_W-1:0] rev);
      arrival_t                 a;
      arrival_t                 batch[afb_pkg::MAX_BATCH];
      bit                       ok;
      bit                       flag;
      int                       lim;
      int                       n;
      logic [afb_pkg::ID_W-1:0] id;
      requests++;
      ok = 1'b0;
      case (act)
        afb_pkg::ACT_RECORD: begin
          if (seq != '0 && now != '0 && rev != '0 && seq > last_seq) begin
            if (queued.size() != 0 && held_rev != rev) begin
              // revision moved under waiting arrivals: feedback due at once
              due_at = now;
            end else if (queued.size() < afb_pkg::QUEUE_DEPTH) begin
              a.seq = seq;
              a.at  = now;
              queued.insert(queued.size(), a);
              last_seq = seq;
              held_rev = rev;
              if (due_at == '0) due_at = rearm(now);
              ok = 1'b1;
            end
          end
          push_result(ok, 1'b0, '0, '0, '0, 1'b1, queued.size(), due_now(now));
        end
        afb_pkg::ACT_TAKE: begin
          if (!due_now(now)) begin
            push_result(1'b0, 1'b0, '0, '0, '0, 1'b1, queued.size(), 1'b0);
          end else begin
            lim = (limit == '0) ? 1 : int'(limit);
            if (lim > afb_pkg::MAX_BATCH) lim = afb_pkg::MAX_BATCH;
            n = (queued.size() < lim) ? queued.size() : lim;
            id = next_id;
            next_id = next_id + 1'b1;
            for (int i = 0; i < n; i++) begin
              batch[i] = queued[0];
              queued.delete(0);
            end
            // due flag on every result reflects the state after the batch
            due_at = (queued.size() == 0) ? '0 : rearm(now);
            flag = due_now(now);
            for (int i = 0; i < n; i++)
              push_result(1'b1, 1'b1, id, held_rev, batch[i], i == n - 1,
                          queued.size() + n - 1 - i, flag);
          end
        end
        afb_pkg::ACT_CLEAR: begin
          clear_state();
          push_result(1'b0, 1'b0, '0, '0, '0, 1'b1, 0, 1'b0);
        end
        default: begin
          push_result(1'b0, 1'b0, '0, '0, '0, 1'b1, queued.size(), due_now(now));
        end
      endcase
    endfunction

    function string show(afb_pkg::res_t r);
      return $sformatf("acc=%0b bv=%0b id=%0h rev=%0h seq=%0h t=%0h last=%0b pend=%0d due=%0b",
                       r.accepted, r.batch_valid, r.batch_id, r.batch_revision,
                       r.arrival_sequence, r.arrival_time, r.last, r.pending, r.due);
    endfunction

    // Compare one result against the oldest awaited one
    function void check_result(afb_pkg::res_t got);
      afb_pkg::res_t want;
      results++;
      if (got.batch_valid && got.last) batches++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch at result %0d", results);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         cfg_we_i       = 1'b0;
  logic [1:0]                   cfg_index_i    = '0;
  logic [afb_pkg::CFG_W-1:0]    cfg_wdata_i    = '0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   action_i       = '0;
  logic [afb_pkg::SEQ_W-1:0]    sequence_req_i = '0;
  logic [afb_pkg::TIME_W-1:0]   now_us_i       = '0;
  logic [afb_pkg::REV_W-1:0]    revision_i     = '0;
  logic                         out_valid_o;
  logic                         out_stall_i    = 1'b0;
  logic                         accepted_o;
  logic                         batch_valid_o;
  logic [afb_pkg::ID_W-1:0]     batch_id_o;
  logic [afb_pkg::REV_W-1:0]    batch_revision_o;
  logic [afb_pkg::SEQ_W-1:0]    arrival_sequence_o;
  logic [afb_pkg::TIME_W-1:0]   arrival_time_us_o;
  logic                         last_o;
  logic [afb_pkg::PEND_W-1:0]   pending_count_o;
  logic                         due_o;

  int                           send_idle_pct = 0;
  int                           stall_pct     = 0;
  int                           cycles        = 0;
  feedback_tracker              tracker;
  logic [afb_pkg::TIME_W-1:0]   clock_us;
  logic [afb_pkg::REV_W-1:0]    gen_rev;

  arrival_feedback_batcher_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .action_i           (action_i),
    .sequence_req_i     (sequence_req_i),
    .now_us_i           (now_us_i),
    .revision_i         (revision_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .accepted_o         (accepted_o),
    .batch_valid_o      (batch_valid_o),
    .batch_id_o         (batch_id_o),
    .batch_revision_o   (batch_revision_o),
    .arrival_sequence_o (arrival_sequence_o),
    .arrival_time_us_o  (arrival_time_us_o),
    .last_o             (last_o),
    .pending_count_o    (pending_count_o),
    .due_o              (due_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles,
               tracker.awaited.size());
      $display("[arrival_feedback_batcher_top] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result({accepted_o, batch_valid_o, batch_id_o, batch_revision_o,
                            arrival_sequence_o, arrival_time_us_o, last_o,
                            pending_count_o, due_o});
  end

  // One request through the input handshake; valid stays up for a following request
  task automatic send_request(afb_pkg::action_e act, logic [afb_pkg::SEQ_W-1:0] seq,
                              logic [afb_pkg::TIME_W-1:0] now,
                              logic [afb_pkg::REV_W-1:0] rev);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    sequence_req_i <= seq;
    now_us_i       <= now;
    revision_i     <= rev;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_request(act, seq, now, rev);
  endtask

  task automatic write_register(afb_pkg::cfg_idx_e idx, logic [afb_pkg::CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    tracker.set_register(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_registers(logic [afb_pkg::IV_W-1:0] iv,
                                   logic [afb_pkg::TRIG_W-1:0] trig,
                                   logic [afb_pkg::LIM_W-1:0] lim);
    write_register(afb_pkg::CFG_INTERVAL, afb_pkg::CFG_W'(iv));
    write_register(afb_pkg::CFG_TRIGGER, afb_pkg::CFG_W'(trig));
    write_register(afb_pkg::CFG_LIMIT, afb_pkg::CFG_W'(lim));
  endtask

  // Wait until every awaited result is in and the back end is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [afb_pkg::REV_W-1:0] record_revision();
    return (tracker.queued.size() != 0) ? tracker.held_rev : gen_rev;
  endfunction

  function automatic logic [afb_pkg::TIME_W-1:0] random_time();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Time advance: half the time small, otherwise half the interval or just past it so that due times pass
  function automatic logic [afb_pkg::TIME_W-1:0] time_step();
    case ($urandom_range(3))
      0:       return afb_pkg::TIME_W'($urandom_range(3));
      1:       return afb_pkg::TIME_W'($urandom_range(200, 1));
      2:       return afb_pkg::TIME_W'(tracker.interval) / 2;
      default: return afb_pkg::TIME_W'(tracker.interval) + afb_pkg::TIME_W'($urandom_range(5));
    endcase
  endfunction

  // Mostly well-formed arrivals and takes, some clears and malformed records
  task automatic random_request();
    logic [afb_pkg::SEQ_W-1:0]  seq;
    logic [afb_pkg::TIME_W-1:0] now;
    logic [afb_pkg::REV_W-1:0]  rev;
    int                         pick;
    pick = $urandom_range(99);
    clock_us = clock_us + time_step();
    now = clock_us;
    seq = tracker.last_seq + afb_pkg::SEQ_W'($urandom_range(4, 1));
    rev = record_revision();
    if (tracker.last_seq > 32'hFFFF_0000 || pick < 3) begin
      send_request(afb_pkg::ACT_CLEAR, $urandom, now, $urandom);
    end else if (pick < 58) begin
      send_request(afb_pkg::ACT_RECORD, seq, now, rev);
    end else if (pick < 82) begin
      send_request(afb_pkg::ACT_TAKE, $urandom, now, $urandom);
    end else if (pick < 84) begin
      send_request(afb_pkg::ACT_NOP, $urandom, now, $urandom);
    end else if (pick < 88) begin
      // new revision: rejected while arrivals wait, otherwise starts a new run
      gen_rev = $urandom_range(32'hFFFF_FFFF, 1);
      send_request(afb_pkg::ACT_RECORD, seq, now, gen_rev);
    end else if (pick < 96) begin
      case ($urandom_range(3))
        0:       send_request(afb_pkg::ACT_RECORD, '0, now, rev);
        1:       send_request(afb_pkg::ACT_RECORD, seq, '0, rev);
        2:       send_request(afb_pkg::ACT_RECORD, seq, now, '0);
        default: send_request(afb_pkg::ACT_RECORD, tracker.last_seq, now, rev);
      endcase
    end else begin
      send_request(afb_pkg::action_e'($urandom_range(3)), $urandom, random_time(),
                   $urandom);
    end
  endtask

  initial begin
    tracker  = new();
    gen_rev  = $urandom_range(32'hFFFF_FFFF, 1);
    clock_us = afb_pkg::TIME_W'($urandom_range(5000, 1000));
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under the reset register values
    send_request(afb_pkg::ACT_TAKE, '0, 5, '0);                  // nothing pending
    send_request(afb_pkg::ACT_NOP, '1, TIME_MAX, '1);            // unused action
    send_request(afb_pkg::ACT_RECORD, '0, 1000, 7);              // zero sequence
    send_request(afb_pkg::ACT_RECORD, 10, '0, 7);                // zero time
    send_request(afb_pkg::ACT_RECORD, 10, 1000, '0);             // zero revision
    send_request(afb_pkg::ACT_RECORD, 10, 1000, 7);              // accepted, arms due time
    send_request(afb_pkg::ACT_RECORD, 10, 1050, 7);              // sequence not increasing
    send_request(afb_pkg::ACT_RECORD, 11, 1100, 7);
    send_request(afb_pkg::ACT_TAKE, '0, 50000, '0);              // not yet due
    send_request(afb_pkg::ACT_TAKE, '0, 101000, '0);             // due by time
    send_request(afb_pkg::ACT_RECORD, 12, 200000, 7);
    send_request(afb_pkg::ACT_RECORD, 13, 200010, 9);            // revision change
    send_request(afb_pkg::ACT_NOP, '0, 200010, '0);
    send_request(afb_pkg::ACT_TAKE, '0, 200010, '0);
    send_request(afb_pkg::ACT_RECORD, '1, TIME_MAX - 5, '1);     // due time saturates
    send_request(afb_pkg::ACT_TAKE, '0, TIME_MAX - 1, '0);
    send_request(afb_pkg::ACT_TAKE, '0, TIME_MAX, '0);
    send_request(afb_pkg::ACT_RECORD, '1, TIME_MAX, '1);         // sequence space exhausted
    send_request(afb_pkg::ACT_CLEAR, '1, TIME_MAX, '1);

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 75; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      if (p > 0) begin
        settle();
        case (p)
          1:       program_registers(1, 1, 1);
          2:       program_registers(24'hFF_FFFF, 256, 64);
          4:       program_registers(0, 0, 0);
          6:       program_registers(50, 8, 3);
          default: program_registers(afb_pkg::IV_W'($urandom_range(5000, 1)),
                                     afb_pkg::TRIG_W'($urandom_range(40, 2)),
                                     afb_pkg::LIM_W'($urandom_range(64, 1)));
        endcase
      end
      if (p == 2) begin
        // fill the queue to the brim, then one more record is refused
        send_request(afb_pkg::ACT_CLEAR, '0, clock_us, '0);
        for (int k = 0; k <= afb_pkg::QUEUE_DEPTH; k++) begin
          clock_us = clock_us + afb_pkg::TIME_W'($urandom_range(3, 1));
          send_request(afb_pkg::ACT_RECORD, tracker.last_seq + 1'b1, clock_us,
                       record_revision());
        end
      end
      if (p == 4) begin
        // take at time zero with a zero interval leaves the due time unarmed
        clock_us = clock_us + 1'b1;
        send_request(afb_pkg::ACT_RECORD, tracker.last_seq + 1'b1, clock_us,
                     record_revision());
        send_request(afb_pkg::ACT_RECORD, tracker.last_seq + 1'b1, clock_us,
                     record_revision());
        send_request(afb_pkg::ACT_TAKE, '0, '0, '0);
      end
      repeat (RANDOM_PER_PHASE) random_request();
    end

    settle();
    $display("covered %0d requests giving %0d results in %0d feedback batches, %0d settings",
             tracker.requests, tracker.results, tracker.batches, PHASES);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("[arrival_feedback_batcher_top] OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", tracker.errors,
               tracker.awaited.size());
      $display("[arrival_feedback_batcher_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== arrival_feedback_batcher_top.f =====
hdl/afb_pkg.sv
hdl/afb_front.sv
hdl/afb_back.sv
hdl/arrival_feedback_batcher_top.sv
tb/arrival_feedback_batcher_top_tb.sv
